// ===== rtl/core/prrp_pkg.sv =====
// Shared types and constants for the posting run record parser.
// Result kinds, error codes and the result record. No dependencies.
package prrp_pkg;

  localparam int unsigned VarintMaxBytes = 10;
  localparam int unsigned WordBytes      = 4;
  localparam int unsigned ValueWidth     = 64;
  localparam int unsigned WordWidth      = 32;

  typedef enum logic [3:0] {
    KTerm     = 4'd0,
    KCount    = 4'd1,
    KDocid    = 4'd2,
    KFreq     = 4'd3,
    KPosCount = 4'd4,
    KPos      = 4'd5,
    KSkip     = 4'd6,
    KRunEnd   = 4'd7,
    KError    = 4'd8
  } kind_e;

  typedef enum logic [2:0] {
    ENone   = 3'd0,
    EWide   = 3'd1,
    EVTrunc = 3'd2,
    ERTrunc = 3'd3,
    EVLong  = 3'd4
  } err_e;

  typedef struct packed {
    kind_e                  kind;
    logic [ValueWidth-1:0]  value;
    logic                   record_end;
    err_e                   error_code;
  } result_t;

endpackage

// ===== rtl/core/posting_run_record_parser.sv =====
// Posting run record parser: LEB128 / raw-word field decoder with APB config.
// Depends on prrp_pkg.
//
// Throughput: one byte per cycle; a result held by a stalled output blocks the input.
// The result is registered: it appears in the output register in the cycle after its byte is accepted.
// The parse step is a single pass from the accepted byte into the result register.
// Reset clears parse state, the sticky error and turns position output on.
module posting_run_record_parser
  import prrp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // byte input
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [7:0]  data_byte_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  kind_o,
  output logic [63:0] value_o,
  output logic        record_end_o,
  output logic [2:0]  error_code_o
);

  typedef enum logic [2:0] {
    PhTerm     = 3'd0,
    PhCount    = 3'd1,
    PhDocid    = 3'd2,
    PhFreq     = 3'd3,
    PhPosCount = 3'd4,
    PhPos      = 3'd5
  } phase_e;

  localparam int unsigned VcntW = $clog2(VarintMaxBytes);
  localparam int unsigned WcntW = $clog2(WordBytes);

  phase_e                phase_q, phase_d;
  logic [ValueWidth-1:0] vacc_q, vacc_d;
  logic [VcntW-1:0]      vcnt_q, vcnt_d;
  logic [WordWidth-1:0]  wacc_q, wacc_d;
  logic [WcntW-1:0]      wcnt_q, wcnt_d;
  logic [WordWidth-1:0]  docid_q, docid_d;
  logic [ValueWidth-1:0] dcount_q, dcount_d;
  logic [ValueWidth-1:0] left_q, left_d;
  logic                  err_hold_q, err_hold_d;
  logic                  has_pos_q;

  result_t               res_q, res_d;
  logic                  res_valid_q;
  logic                  res_load;

  logic                  in_fire;
  logic                  cfg_wr;

  logic [ValueWidth-1:0] v_full;
  logic [5:0]            v_shamt;
  logic [WordWidth-1:0]  w_full;
  logic [ValueWidth-1:0] left_dec;
  logic                  left_last;
  logic [WordWidth-1:0]  docid_sum;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = paddr[2] ? 32'd0 : {31'd0, has_pos_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      has_pos_q <= 1'b1;
    end else if (cfg_wr && !paddr[2]) begin
      has_pos_q <= pwdata[0];
    end
  end

  // ---------------------------------------------------------------- handshake
  assign in_ready_o = !res_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // ---------------------------------------------------------------- datapath
  assign v_shamt   = 6'(7 * vcnt_q);
  assign v_full    = vacc_q | (ValueWidth'(data_byte_i[6:0]) << v_shamt);
  assign w_full    = wacc_q | (WordWidth'(data_byte_i) << {wcnt_q, 3'b000});
  assign left_dec  = (left_q != '0) ? left_q - ValueWidth'(1) : '0;
  assign left_last = (left_q[ValueWidth-1:1] == '0);
  assign docid_sum = docid_q + v_full[WordWidth-1:0];

  always_comb begin
    phase_d    = phase_q;
    vacc_d     = vacc_q;
    vcnt_d     = vcnt_q;
    wacc_d     = wacc_q;
    wcnt_d     = wcnt_q;
    docid_d    = docid_q;
    dcount_d   = dcount_q;
    left_d     = left_q;
    err_hold_d = err_hold_q;
    res_load   = 1'b0;
    res_d      = '{kind: KTerm, value: '0, record_end: 1'b0, error_code: ENone};

    if (in_fire && !err_hold_q) begin
      if (action_i) begin
        res_load = 1'b1;
        if (phase_q == PhTerm && vcnt_q == '0) begin
          res_d.kind = KRunEnd;
        end else begin
          err_hold_d = 1'b1;
          res_d.kind = KError;
          res_d.error_code = (phase_q == PhFreq || phase_q == PhPos) ? ERTrunc : EVTrunc;
        end
      end else if (phase_q == PhFreq || phase_q == PhPos) begin
        if (wcnt_q == WcntW'(WordBytes - 1)) begin
          wacc_d = '0;
          wcnt_d = '0;
          left_d = left_dec;
          if (phase_q == PhFreq) begin
            res_load    = 1'b1;
            res_d.kind  = KFreq;
            res_d.value = ValueWidth'(w_full);
            if (left_last) phase_d = PhPosCount;
          end else if (left_last) begin
            // last position closes the record; a skipped block ends with a marker
            phase_d          = PhTerm;
            res_load         = 1'b1;
            res_d.record_end = 1'b1;
            if (has_pos_q) begin
              res_d.kind  = KPos;
              res_d.value = ValueWidth'(w_full);
            end else begin
              res_d.kind = KSkip;
            end
          end else if (has_pos_q) begin
            res_load    = 1'b1;
            res_d.kind  = KPos;
            res_d.value = ValueWidth'(w_full);
          end
        end else begin
          wacc_d = w_full;
          wcnt_d = wcnt_q + WcntW'(1);
        end
      end else if (data_byte_i[7]) begin
        if (vcnt_q == VcntW'(VarintMaxBytes - 1)) begin
          err_hold_d       = 1'b1;
          res_load         = 1'b1;
          res_d.kind       = KError;
          res_d.error_code = EVLong;
        end else begin
          vacc_d = v_full;
          vcnt_d = vcnt_q + VcntW'(1);
        end
      end else begin
        vacc_d   = '0;
        vcnt_d   = '0;
        res_load = 1'b1;
        unique case (phase_q)
          PhTerm: begin
            if (v_full[ValueWidth-1:WordWidth] != '0) begin
              err_hold_d       = 1'b1;
              res_d.kind       = KError;
              res_d.error_code = EWide;
            end else begin
              phase_d     = PhCount;
              res_d.kind  = KTerm;
              res_d.value = v_full;
            end
          end
          PhCount: begin
            dcount_d    = v_full;
            left_d      = v_full;
            docid_d     = '0;
            phase_d     = (v_full == '0) ? PhPosCount : PhDocid;
            res_d.kind  = KCount;
            res_d.value = v_full;
          end
          PhDocid: begin
            docid_d     = docid_sum;
            left_d      = left_dec;
            res_d.kind  = KDocid;
            res_d.value = ValueWidth'(docid_sum);
            if (left_last) begin
              left_d  = dcount_q;
              phase_d = (dcount_q == '0) ? PhPosCount : PhFreq;
            end
          end
          default: begin
            left_d      = v_full;
            res_d.kind  = KPosCount;
            res_d.value = v_full;
            if (v_full == '0) begin
              phase_d          = PhTerm;
              res_d.record_end = 1'b1;
            end else begin
              phase_d = PhPos;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhTerm;
      vacc_q      <= '0;
      vcnt_q      <= '0;
      wacc_q      <= '0;
      wcnt_q      <= '0;
      docid_q     <= '0;
      dcount_q    <= '0;
      left_q      <= '0;
      err_hold_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      vacc_q     <= vacc_d;
      vcnt_q     <= vcnt_d;
      wacc_q     <= wacc_d;
      wcnt_q     <= wcnt_d;
      docid_q    <= docid_d;
      dcount_q   <= dcount_d;
      left_q     <= left_d;
      err_hold_q <= err_hold_d;
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // hold payload until the next result is loaded
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o  = res_valid_q;
  assign kind_o       = res_q.kind;
  assign value_o      = res_q.value;
  assign record_end_o = res_q.record_end;
  assign error_code_o = res_q.error_code;

  // ---------------------------------------------------------------- assertions
  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_hold_q |=> err_hold_q)
    else $error("sticky error flag cleared");

  a_err_flagged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == KError) |-> err_hold_q)
    else $error("error result without sticky flag");

  a_no_result_after_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_hold_q && !out_valid_o) |=> !out_valid_o)
    else $error("result produced after error");

  a_code_matches_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((kind_o == KError) == (error_code_o != ENone)))
    else $error("error code does not match result kind");

  a_rec_end_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && record_end_o) |->
      (kind_o == KPosCount || kind_o == KPos || kind_o == KSkip))
    else $error("record end on wrong kind");

  a_word_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wcnt_q != '0) |-> (phase_q == PhFreq || phase_q == PhPos))
    else $error("partial word outside raw block");

endmodule

// ===== bench/posting_run_record_parser_tb.sv =====
// Self-checking bench for posting_run_record_parser: byte stream in, decoded fields out.
// Depends on prrp_pkg and the parser RTL; models the field decoder internally.
module posting_run_record_parser_tb
  import prrp_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] PosEnableAddr    = 3'd0;
  localparam logic [2:0] UnmappedAddr     = 3'd4;
  localparam int unsigned CycleLimit      = 300_000;
  localparam int unsigned PhaseItems      = 150;

  typedef enum logic [2:0] {
    FldTerm, FldCount, FldDocid, FldFreq, FldPosCount, FldPos
  } field_e;

  typedef struct packed {
    logic    act;
    logic [7:0] data;
    logic    typed;
    result_t res;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        action_i;
  logic [7:0]  data_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [3:0]  kind_o;
  logic [63:0] value_o;
  logic        record_end_o;
  logic [2:0]  error_code_o;

  posting_run_record_parser uut (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o, .action_i, .data_byte_i,
    .out_valid_o, .out_ready_i, .kind_o, .value_o, .record_end_o, .error_code_o
  );

  // decoder model state
  logic        positions_on;
  field_e      field;
  logic [63:0] var_acc;
  int unsigned vbytes;
  logic [31:0] word_acc;
  logic [1:0]  wbytes;
  logic [31:0] docid_sum;
  logic [63:0] doc_total;
  logic [63:0] left;
  logic        error_seen;

  result_t     expected_q[$];
  logic [8:0]  byte_stream[$];
  logic        item_typed;
  result_t     item_result;
  bit          tx_calm;
  bit          rx_calm;
  int unsigned mismatches;
  int unsigned cycle_count;

  function automatic stim_row_t row(input logic act, input logic [7:0] data,
                                    input logic typed = 1'b0, input kind_e kind = KTerm,
                                    input logic [63:0] value = '0,
                                    input logic rend = 1'b0, input err_e code = ENone);
    stim_row_t r;
    r.act = act;
    r.data = data;
    r.typed = typed;
    r.res.kind = kind;
    r.res.value = value;
    r.res.record_end = rend;
    r.res.error_code = code;
    return r;
  endfunction

  // Advance the model by one byte or end-of-run marker; 1 when a result is produced.
  function automatic logic decode_transfer(input logic act, input logic [7:0] data,
                                           output result_t res);
    logic [63:0] v;
    logic [31:0] w;
    res = '0;
    if (error_seen) return 1'b0;
    if (act) begin
      if (field == FldTerm && vbytes == 0) begin
        res.kind = KRunEnd;
        return 1'b1;
      end
      error_seen = 1'b1;
      res.kind = KError;
      if (field == FldFreq || field == FldPos) res.error_code = ERTrunc;
      else res.error_code = EVTrunc;
      return 1'b1;
    end

    if (field == FldFreq || field == FldPos) begin
      word_acc = word_acc | (32'(data) << (8 * wbytes));
      if (wbytes != 2'(WordBytes - 1)) begin
        wbytes++;
        return 1'b0;
      end
      w = word_acc;
      word_acc = '0;
      wbytes = '0;
      if (left != 0) left--;
      if (field == FldFreq) begin
        if (left == 0) field = FldPosCount;
        res.kind = KFreq;
        res.value = 64'(w);
        return 1'b1;
      end
      if (left == 0) begin
        field = FldTerm;
        res.record_end = 1'b1;
        if (positions_on) begin
          res.kind = KPos;
          res.value = 64'(w);
        end else begin
          res.kind = KSkip;
        end
        return 1'b1;
      end
      if (!positions_on) return 1'b0;
      res.kind = KPos;
      res.value = 64'(w);
      return 1'b1;
    end

    // payload bits beyond bit 63 fall off the shift
    if (vbytes < VarintMaxBytes) var_acc = var_acc | (64'(data[6:0]) << (7 * vbytes));
    if (data[7]) begin
      if (vbytes + 1 >= VarintMaxBytes) begin
        error_seen = 1'b1;
        res.kind = KError;
        res.error_code = EVLong;
        return 1'b1;
      end
      vbytes++;
      return 1'b0;
    end
    v = var_acc;
    var_acc = '0;
    vbytes = 0;

    case (field)
      FldTerm: begin
        if (v > 64'hFFFF_FFFF) begin
          error_seen = 1'b1;
          res.kind = KError;
          res.error_code = EWide;
        end else begin
          field = FldCount;
          res.kind = KTerm;
          res.value = v;
        end
      end
      FldCount: begin
        doc_total = v;
        left = v;
        docid_sum = '0;
        if (v == 0) field = FldPosCount;
        else field = FldDocid;
        res.kind = KCount;
        res.value = v;
      end
      FldDocid: begin
        docid_sum = docid_sum + v[31:0];
        if (left != 0) left--;
        if (left == 0) begin
          left = doc_total;
          if (doc_total == 0) field = FldPosCount;
          else field = FldFreq;
        end
        res.kind = KDocid;
        res.value = 64'(docid_sum);
      end
      default: begin
        left = v;
        res.kind = KPosCount;
        res.value = v;
        if (v == 0) begin
          field = FldTerm;
          res.record_end = 1'b1;
        end else begin
          field = FldPos;
        end
      end
    endcase
    return 1'b1;
  endfunction

  function automatic logic [63:0] rand_wide();
    case ($urandom_range(0, 3))
      0: return 64'($urandom_range(0, 127));
      1: return 64'($urandom());
      2: return {$urandom(), $urandom()} >> $urandom_range(0, 63);
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // Encode v as LEB128, optionally padded out to as many as ten bytes.
  function automatic void put_varint(input logic [63:0] v, input bit pad);
    int unsigned len;
    int unsigned n;
    logic [7:0] b;
    len = 1;
    for (int i = 1; i < VarintMaxBytes; i++) if ((v >> (7 * i)) != 0) len = i + 1;
    n = pad ? $urandom_range(len, VarintMaxBytes) : len;
    for (int i = 0; i < n; i++) begin
      b = {i < n - 1, 7'(v >> (7 * i))};
      // tenth byte: only bit 0 is payload, the rest is ignored
      if (i == VarintMaxBytes - 1) b[6:1] = 6'($urandom());
      byte_stream.insert(byte_stream.size(), {1'b0, b});
    end
  endfunction

  function automatic void put_word(input logic [31:0] w);
    for (int i = 0; i < WordBytes; i++)
      byte_stream.insert(byte_stream.size(), {1'b0, w[8*i +: 8]});
  endfunction

  task automatic send_item(input stim_row_t r);
    int unsigned gap;
    gap = tx_calm ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    action_i = r.act;
    data_byte_i = r.data;
    item_typed = r.typed;
    item_result = r.res;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i = 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == PosEnableAddr) positions_on = data[0];
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Predict on every input transfer, check every output transfer.
  always @(posedge clk_i) begin
    result_t predicted;
    result_t want;
    logic produced;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        produced = decode_transfer(action_i, data_byte_i, predicted);
        if (item_typed) expected_q.insert(expected_q.size(), item_result);
        else if (produced) expected_q.insert(expected_q.size(), predicted);
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: kind=%0d value=%h rend=%0b code=%0d",
                     kind_o, value_o, record_end_o, error_code_o);
        end else begin
          want = expected_q.pop_front();
          if (kind_o !== want.kind || value_o !== want.value ||
              record_end_o !== want.record_end || error_code_o !== want.error_code) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: want kind=%0d value=%h rend=%0b code=%0d, got %0d %h %0b %0d",
                       want.kind, want.value, want.record_end, want.error_code,
                       kind_o, value_o, record_end_o, error_code_o);
          end
        end
      end
    end
  end

  // Result side: draw a stall per result, then hold ready until a transfer.
  initial begin
    int unsigned stall;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      stall = rx_calm ? 0 : $urandom_range(0, 17);
      if (stall != 0) begin
        out_ready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    stim_row_t rows[$];
    int unsigned count;
    int unsigned docs;
    int unsigned poss;
    logic [31:0] term;
    logic setting;

    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid_i = 1'b0;
    action_i = 1'b0;
    data_byte_i = '0;
    item_typed = 1'b0;
    item_result = '0;
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    mismatches = 0;
    cycle_count = 0;
    positions_on = 1'b1;
    field = FldTerm;
    var_acc = '0;
    vbytes = 0;
    word_acc = '0;
    wbytes = '0;
    docid_sum = '0;
    doc_total = '0;
    left = '0;
    error_seen = 1'b0;

    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    rows = '{
      row(1'b1, 8'h5A, 1'b1, KRunEnd),                     // end of run between records
      row(1'b0, 8'h00, 1'b1, KTerm, 64'd0),
      row(1'b0, 8'h00, 1'b1, KCount, 64'd0),               // no docs: straight to pos count
      row(1'b0, 8'h00, 1'b1, KPosCount, 64'd0, 1'b1),      // empty record closes here
      row(1'b0, 8'hFF), row(1'b0, 8'hFF), row(1'b0, 8'hFF), row(1'b0, 8'hFF),
      row(1'b0, 8'h0F, 1'b1, KTerm, 64'hFFFF_FFFF),        // widest legal term id
      row(1'b0, 8'h01, 1'b1, KCount, 64'd1),
      row(1'b0, 8'hFF), row(1'b0, 8'hFF), row(1'b0, 8'hFF), row(1'b0, 8'hFF),
      row(1'b0, 8'hFF), row(1'b0, 8'hFF), row(1'b0, 8'hFF), row(1'b0, 8'hFF),
      row(1'b0, 8'hFF),
      row(1'b0, 8'h7F, 1'b1, KDocid, 64'hFFFF_FFFF),       // ten bytes, excess bits dropped
      row(1'b0, 8'hFF), row(1'b0, 8'hFF), row(1'b0, 8'hFF),
      row(1'b0, 8'hFF, 1'b1, KFreq, 64'hFFFF_FFFF),
      row(1'b0, 8'h01, 1'b1, KPosCount, 64'd1),
      row(1'b0, 8'h78), row(1'b0, 8'h56), row(1'b0, 8'h34),
      row(1'b0, 8'h12, 1'b0)
    };
    foreach (rows[i]) send_item(rows[i]);

    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) begin
        // idle mid-stream is fine: a skipped position block can be split here
        wait_idle();
        if (ph == 2) write_reg(UnmappedAddr, $urandom());
        setting = (ph == 4) ? 1'($urandom_range(0, 1)) : 1'(ph % 2 == 0);
        write_reg(PosEnableAddr, {31'($urandom()), setting});
      end
      count = 0;
      while (count < PhaseItems) begin
        if (count % 40 == 0) begin
          tx_calm = $urandom_range(0, 3) == 0;
          rx_calm = $urandom_range(0, 3) == 0;
        end
        if (byte_stream.size() == 0) begin
          if ($urandom_range(0, 5) == 0)
            byte_stream.insert(byte_stream.size(), {1'b1, 8'($urandom())});
          term = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF : $urandom() >> $urandom_range(0, 31);
          put_varint(64'(term), $urandom_range(0, 3) == 0);
          docs = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 4);
          put_varint(64'(docs), $urandom_range(0, 3) == 0);
          repeat (docs) put_varint(rand_wide(), $urandom_range(0, 3) == 0);
          repeat (docs) put_word($urandom());
          poss = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8) : $urandom_range(0, 4);
          put_varint(64'(poss), $urandom_range(0, 3) == 0);
          repeat (poss) put_word($urandom());
        end
        send_item(row(byte_stream[0][8], byte_stream[0][7:0]));
        void'(byte_stream.pop_front());
        count++;
      end
    end

    // Finish the open record, then end the run with one sticky error.
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    case ($urandom_range(0, 3))
      0: put_varint({$urandom() | 32'h1, $urandom()}, $urandom_range(0, 1));
      1: begin
        if ($urandom_range(0, 1)) begin
          put_varint(64'($urandom()), 1'b0);
          put_varint(64'd1, 1'b0);
        end
        repeat (VarintMaxBytes)
          byte_stream.insert(byte_stream.size(), {1'b0, 1'b1, 7'($urandom())});
      end
      2: begin
        put_varint(64'($urandom()), 1'b0);
        if ($urandom_range(0, 1)) begin
          put_varint({$urandom() | 32'h8000_0000, $urandom()}, 1'b0);
          repeat ($urandom_range(0, 2)) put_varint(rand_wide(), 1'b0);
        end
        repeat ($urandom_range(0, 3))
          byte_stream.insert(byte_stream.size(), {1'b0, 1'b1, 7'($urandom())});
        byte_stream.insert(byte_stream.size(), {1'b1, 8'($urandom())});
      end
      default: begin
        put_varint(64'($urandom()), 1'b0);
        if ($urandom_range(0, 1)) begin
          put_varint(64'd2, 1'b0);
          put_varint(rand_wide(), 1'b0);
          put_varint(rand_wide(), 1'b0);
          repeat ($urandom_range(0, 1)) put_word($urandom());
        end else begin
          put_varint(64'd0, 1'b0);
          put_varint({$urandom() | 32'h8000_0000, $urandom()}, 1'b0);
          repeat ($urandom_range(0, 3)) put_word($urandom());
        end
        repeat ($urandom_range(0, 3))
          byte_stream.insert(byte_stream.size(), {1'b0, 8'($urandom())});
        byte_stream.insert(byte_stream.size(), {1'b1, 8'($urandom())});
      end
    endcase
    // after the error everything is dropped
    repeat (6) byte_stream.insert(byte_stream.size(), 9'($urandom()));
    while (byte_stream.size() != 0) begin
      send_item(row(byte_stream[0][8], byte_stream[0][7:0]));
      void'(byte_stream.pop_front());
    end

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/prrp_pkg.sv
rtl/core/posting_run_record_parser.sv
bench/posting_run_record_parser_tb.sv
